// ===== sv/fbfl_pkg.sv =====
// shared types and codes for the fixed block free list allocator
// no dependencies
package fbfl_pkg;

    localparam logic [1:0] MODE_ALLOCATE = 2'd0;
    localparam logic [1:0] MODE_RELEASE  = 2'd1;
    localparam logic [1:0] MODE_REBUILD  = 2'd2;

    localparam logic [2:0] STATUS_GRANTED  = 3'd0;
    localparam logic [2:0] STATUS_EMPTY    = 3'd1;
    localparam logic [2:0] STATUS_RELEASED = 3'd2;
    localparam logic [2:0] STATUS_REBUILT  = 3'd3;
    localparam logic [2:0] STATUS_REJECTED = 3'd4;

    localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_BLOCK_SIZE   = 2'd1;
    localparam logic [1:0] CFG_BLOCK_COUNT  = 2'd2;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_POP,
        FSM_MUL,
        FSM_BUILD,
        FSM_RESULT
    } fsm_state_t;

    typedef struct packed {
        logic [31:0] base_address;
        logic [15:0] blk_bytes;
        logic [8:0]  blk_total;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  granted_index;
        logic [31:0] granted_address;
    } res_t;

endpackage

// ===== sv/fbfl_link_ram.sv =====
// next-link memory: one write port, one read port, registered read data
// no dependencies
module fbfl_link_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 9
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/fbfl_ctrl.sv =====
// free list sequencer: head register, pop/push/rebuild over the link memory
// depends on fbfl_pkg
module fbfl_ctrl #(
    parameter int MAX_BLOCKS = 256,
    parameter int IW = $clog2(MAX_BLOCKS),
    parameter int LW = IW + 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fbfl_pkg::cfg_t     cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [7:0]         s_block_index,
    input  logic               out_free,
    output logic               res_valid,
    output fbfl_pkg::res_t     res,
    output logic               ram_we,
    output logic [IW-1:0]      ram_waddr,
    output logic [LW-1:0]      ram_wdata,
    output logic               ram_re,
    output logic [IW-1:0]      ram_raddr,
    input  logic [LW-1:0]      ram_rdata
);
    import fbfl_pkg::*;

    localparam int CW = (LW > 9) ? LW : 9;
    localparam int PW = IW + 16;
    localparam logic [LW-1:0] HEAD_EMPTY = LW'(MAX_BLOCKS);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

    fsm_state_t     state_reg, state_next;
    logic [LW-1:0]  head_reg, head_next;
    logic [IW-1:0]  cnt_reg, cnt_next;
    logic [PW-1:0]  prod_reg, prod_next;
    res_t           res_reg, res_next;

    logic [CW-1:0]  eff_count;
    logic           in_accept;
    logic           list_empty;
    logic           idx_ok;
    logic           build_last;

    always_comb begin
        eff_count  = (CW'(cfg.blk_total) > MAX_C) ? MAX_C : CW'(cfg.blk_total);
        in_accept  = s_valid && s_ready;
        list_empty = head_reg >= HEAD_EMPTY;
        idx_ok     = CW'(s_block_index) < eff_count;
        build_last = (CW'(cnt_reg) + CW'(1)) == eff_count;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (in_accept) begin
                    if (s_mode == MODE_ALLOCATE && !list_empty) begin
                        state_next = FSM_POP;
                    end else if (s_mode == MODE_REBUILD && eff_count != '0) begin
                        state_next = FSM_BUILD;
                    end else begin
                        state_next = FSM_RESULT;
                    end
                end
            end
            FSM_POP:   state_next = FSM_MUL;
            FSM_MUL:   state_next = FSM_RESULT;
            FSM_BUILD: begin
                if (build_last) begin
                    state_next = FSM_RESULT;
                end
            end
            FSM_RESULT: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = 1'b0;
        res_valid = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = IW'(s_block_index);
        ram_wdata = head_reg;
        ram_re    = 1'b0;
        ram_raddr = head_reg[IW-1:0];
        unique case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                ram_re  = in_accept && s_mode == MODE_ALLOCATE && !list_empty;
                ram_we  = in_accept && s_mode == MODE_RELEASE && idx_ok;
                ram_waddr = IW'(s_block_index);
            end
            FSM_BUILD: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
            end
            FSM_RESULT: begin
                res_valid = out_free;
            end
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        res_next  = res_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (in_accept) begin
                    res_next = '{status: STATUS_REJECTED, granted_index: '0,
                                 granted_address: '0};
                    case (s_mode)
                        MODE_ALLOCATE: begin
                            if (list_empty) begin
                                res_next.status = STATUS_EMPTY;
                            end
                        end
                        MODE_RELEASE: begin
                            if (idx_ok) begin
                                head_next       = LW'(s_block_index);
                                res_next.status = STATUS_RELEASED;
                            end
                        end
                        MODE_REBUILD: begin
                            head_next       = HEAD_EMPTY;
                            cnt_next        = '0;
                            res_next.status = STATUS_REBUILT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            FSM_POP: begin
                prod_next = PW'(head_reg[IW-1:0]) * PW'(cfg.blk_bytes);
                res_next.status        = STATUS_GRANTED;
                res_next.granted_index = 8'(head_reg[IW-1:0]);
                head_next = (ram_rdata >= HEAD_EMPTY) ? HEAD_EMPTY : ram_rdata;
            end
            FSM_MUL: begin
                res_next.granted_address = cfg.base_address + 32'(prod_reg);
            end
            FSM_BUILD: begin
                head_next = LW'(cnt_reg);
                cnt_next  = cnt_reg + IW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
            head_reg  <= HEAD_EMPTY;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

    head_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= HEAD_EMPTY)
        else $error("free list head out of range");

    build_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_BUILD |-> CW'(cnt_reg) < eff_count)
        else $error("rebuild ran past the block count");

    no_write_in_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_POP || state_reg == FSM_MUL) |-> !ram_we)
        else $error("link write while a pop is in flight");

    pop_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_POP |-> $past(ram_re))
        else $error("pop without a link read");

endmodule

// ===== sv/fixed_block_free_list_allocator_core.sv =====
// top level of the fixed block free list allocator: config registers, result register
// depends on fbfl_pkg, fbfl_ctrl, fbfl_link_ram
//
// Usage:
//   s_ channel takes one item: s_mode (0 allocate, 1 release, 2 rebuild) and
//   s_block_index (used by release). Every item gives exactly one result on the
//   m_ channel: m_status, m_granted_index, m_granted_address.
//   Config writes (cfg_wr_en, cfg_index, cfg_wr_data) set the base address,
//   the bytes per block and the block count; write them only while the block is idle.
//   Release, reject and empty allocate go straight to the result; a granted
//   allocate reads the link memory, then does the address multiply and add;
//   rebuild does one link memory write per block.
//   One item is worked on at a time; s_ready is high only when the sequencer
//   is idle. The result register lets the sequencer finish an item while the
//   previous result waits; when m_ready stays low the next result holds in the
//   sequencer and s_ready stays low.
//   Reset: registers go to base 0, size 8, count 256, and the pool is empty
//   until a rebuild item arrives. The link memory is not cleared.
module fixed_block_free_list_allocator_core #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_block_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_granted_index,
    output logic [31:0] m_granted_address
);
    import fbfl_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = IW + 1;

    cfg_t          cfg_reg, cfg_next;
    logic          m_valid_reg, m_valid_next;
    res_t          out_reg, out_next;

    logic          out_free;
    logic          res_valid;
    res_t          res;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [LW-1:0] ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [LW-1:0] ram_rdata;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS: cfg_next.base_address = cfg_wr_data;
                CFG_BLOCK_SIZE:   cfg_next.blk_bytes    = cfg_wr_data[15:0];
                CFG_BLOCK_COUNT:  cfg_next.blk_total    = cfg_wr_data[8:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '{base_address: 32'd0, blk_bytes: 16'd8, blk_total: 9'd256};
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    fbfl_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IW         (IW),
        .LW         (LW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_block_index (s_block_index),
        .out_free      (out_free),
        .res_valid     (res_valid),
        .res           (res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    fbfl_link_ram #(
        .ADDR_W (IW),
        .DATA_W (LW)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid           = m_valid_reg;
    assign m_status          = out_reg.status;
    assign m_granted_index   = out_reg.granted_index;
    assign m_granted_address = out_reg.granted_address;

endmodule
